// File: rtl/tsf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tsf_pkg
// Shared types, constants and helpers of the scanline triangle fill block.
// ============================================================================
package tsf_pkg;

  // Frame store geometry.
  localparam int FB_WIDTH   = 64;
  localparam int FB_HEIGHT  = 64;
  localparam int CHANNELS   = 3;
  localparam int COL_W      = $clog2(FB_WIDTH);
  localparam int ROW_W      = $clog2(FB_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int CH_W       = 8;
  localparam int PIX_W      = CHANNELS * CH_W;

  // Arithmetic widths.
  localparam int CRD_W      = 12;   // vertex coordinate
  localparam int FRAC_W     = 16;   // fraction bits of edge positions
  localparam int SLOPE_W    = 29;   // signed slope, Q12.16 plus sign
  localparam int QMAG_W     = 28;   // magnitude of a slope quotient
  localparam int POS_W      = 34;   // signed edge position accumulator
  localparam int YW         = 13;   // row counter, one past the coordinate range
  localparam int CLIP_W     = 6;
  localparam int CNT_W      = $clog2(QMAG_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [FRAC_W-1:0] HALF_Q16   = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_CHAN0 = 3'd0,
    REG_FILL_CHAN1 = 3'd1,
    REG_FILL_CHAN2 = 3'd2,
    REG_FILL_ALPHA = 3'd3,
    REG_CLIP_MIN_X = 3'd4,
    REG_CLIP_MAX_X = 3'd5,
    REG_CLIP_MIN_Y = 3'd6,
    REG_CLIP_MAX_Y = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    KIND_DONE  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    operation;
    logic signed [CRD_W-1:0] first_x;
    logic signed [CRD_W-1:0] first_y;
    logic signed [CRD_W-1:0] second_x;
    logic signed [CRD_W-1:0] second_y;
    logic signed [CRD_W-1:0] third_x;
    logic signed [CRD_W-1:0] third_y;
    logic [5:0]              read_col;
    logic [5:0]              read_row;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] pixel_chan0;
    logic [CH_W-1:0] pixel_chan1;
    logic [CH_W-1:0] pixel_chan2;
    logic [CH_W-1:0] pixel_chan3;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_SORT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_INIT,
    ST_ROW,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_DONE
  } state_t;

  // Divider request and response.
  typedef struct packed {
    logic                      start;
    logic signed [SLOPE_W-1:0] dividend;
    logic [CRD_W-1:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] quotient;
  } div_rsp_t;

  // Frame store access.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Integer coordinate to a signed Q.16 edge position.
  function automatic logic signed [POS_W-1:0] coord_to_pos(logic signed [CRD_W-1:0] c);
    coord_to_pos = $signed({{(POS_W-CRD_W-FRAC_W){c[CRD_W-1]}}, c, {FRAC_W{1'b0}}});
  endfunction

  // Slope widened to the accumulator width.
  function automatic logic signed [POS_W-1:0] slope_to_pos(logic signed [SLOPE_W-1:0] s);
    slope_to_pos = $signed({{(POS_W-SLOPE_W){s[SLOPE_W-1]}}, s});
  endfunction

endpackage

// File: rtl/tsf_div.sv
`timescale 1ns / 1ps
// ============================================================================
// tsf_div
// Iterative signed divider for edge slopes, one quotient bit per cycle.
// ============================================================================
module tsf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tsf_pkg::div_req_t req,
  output tsf_pkg::div_rsp_t rsp
);
  import tsf_pkg::*;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CRD_W-1:0]    rem_r, rem_nxt;
  logic [QMAG_W-1:0]   quo_r, quo_nxt;
  logic [CRD_W-1:0]    den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [SLOPE_W-1:0]  mag;
  logic [CRD_W+1:0]    trial;

  // Magnitude of the dividend and one restoring subtract step.
  assign mag   = req.dividend[SLOPE_W-1] ? SLOPE_W'(-req.dividend) : req.dividend;
  assign trial = {1'b0, rem_r, quo_r[QMAG_W-1]} - {2'b00, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(QMAG_W - 1);
      rem_nxt = '0;
      quo_nxt = mag[QMAG_W-1:0];
      den_nxt = req.divisor;
      neg_nxt = req.dividend[SLOPE_W-1];
    end else if (run_r) begin
      if (trial[CRD_W+1]) begin
        rem_nxt = {rem_r[CRD_W-2:0], quo_r[QMAG_W-1]};
        quo_nxt = {quo_r[QMAG_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[CRD_W-1:0];
        quo_nxt = {quo_r[QMAG_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Quotient truncates toward zero: negate the magnitude for a negative dividend.
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// File: rtl/tsf_blend.sv
`timescale 1ns / 1ps
// ============================================================================
// tsf_blend
// Per-channel alpha blend of the fill color over a stored pixel.
// ============================================================================
module tsf_blend (
  input  logic [tsf_pkg::PIX_W-1:0] pix_in,
  input  logic [tsf_pkg::PIX_W-1:0] fill,
  input  logic [tsf_pkg::CH_W-1:0]  alpha,
  output logic [tsf_pkg::PIX_W-1:0] pix_out
);
  import tsf_pkg::*;

  logic [CH_W-1:0] inv_alpha;

  assign inv_alpha = ALPHA_OPAQUE - alpha;

  // Each channel: (c*a + t*(255-a)) / 255, the division done as
  // (s + 1 + (s >> 8)) >> 8, which is exact for a 16-bit sum.
  always_comb begin
    logic [2*CH_W:0] sum;
    logic [2*CH_W:0] q;
    pix_out = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum = (2*CH_W+1)'(fill[ch*CH_W +: CH_W]) * (2*CH_W+1)'(alpha)
          + (2*CH_W+1)'(pix_in[ch*CH_W +: CH_W]) * (2*CH_W+1)'(inv_alpha);
      q   = sum + (2*CH_W+1)'(1) + (sum >> CH_W);
      if (alpha == ALPHA_OPAQUE) begin
        pix_out[ch*CH_W +: CH_W] = fill[ch*CH_W +: CH_W];
      end else begin
        pix_out[ch*CH_W +: CH_W] = q[2*CH_W-1:CH_W];
      end
    end
  end

endmodule

// File: rtl/tsf_fstore.sv
`timescale 1ns / 1ps
// ============================================================================
// tsf_fstore
// Frame store: one write port and one registered read port.
// ============================================================================
module tsf_fstore (
  input  logic                      clk,
  input  tsf_pkg::mem_req_t         req,
  output logic [tsf_pkg::PIX_W-1:0] rdata
);
  import tsf_pkg::*;

  logic [PIX_W-1:0] mem [FB_WIDTH*FB_HEIGHT];
  logic [PIX_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/triangle_scanline_fill_core.sv
`timescale 1ns / 1ps
// ============================================================================
// triangle_scanline_fill_core
// Scanline triangle filler with alpha blend into a 64 x 64 RGB frame store.
//
//   Channel   Ports                          Handshake
//   input     start, busy, in_item           taken when start high, busy low
//   result    out_valid, out_item            one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_wdata   written when cfg_we high
//
// After reset a clearing pass zeroes the frame store with busy high. A read
// item passes through a request state and a data state. A draw item computes
// three slopes in the shared divider, a flat edge skipping the divider, then
// walks the rows: each pixel covered is a read and a write back through the
// single frame store port pair.
// ============================================================================
module triangle_scanline_fill_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tsf_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  output tsf_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tsf_pkg::*;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CH_W-1:0]   fill0_r, fill1_r, fill2_r, alpha_r;
  logic [CLIP_W-1:0] cminx_r, cmaxx_r, cminy_r, cmaxy_r;

  // Item and walk state.
  logic [ADDR_W-1:0]         clr_addr_r, clr_addr_nxt;
  in_item_t                  item_r, item_nxt;
  logic signed [CRD_W-1:0]   ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [CRD_W-1:0]   ax_nxt, ay_nxt, bx_nxt, by_nxt, cx_nxt, cy_nxt;
  logic signed [SLOPE_W-1:0] dx1_r, dx2_r, dx3_r, dx1_nxt, dx2_nxt, dx3_nxt;
  logic [1:0]                dsel_r, dsel_nxt;
  logic signed [POS_W-1:0]   sx_r, ex_r, sx_nxt, ex_nxt;
  logic signed [YW-1:0]      y_r, y_nxt;
  logic                      phase_r, phase_nxt;
  logic                      sel_r, sel_nxt;
  logic [COL_W-1:0]          col_r, col_nxt, ce_r, ce_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  mem_req_t         mem_req;
  logic [PIX_W-1:0] mem_rdata;
  logic [PIX_W-1:0] blend_out;

  // Slope operands for the edge selected by dsel_r.
  logic signed [CRD_W:0]     d_x, d_y;
  logic signed [SLOPE_W-1:0] flat_slope;
  logic                      dy_zero;

  // Row and span terms.
  logic signed [YW-1:0]      end_y;
  logic                      row_over;
  logic signed [POS_W-1:0]   lo_pos, hi_pos, xs_c, xe_c, xs_r, xe_r;
  logic                      drop;
  logic [COL_W-1:0]          cs, ce;
  logic                      span_live;
  logic [COL_W:0]            col_inc;
  logic signed [POS_W-1:0]   inc_s, inc_e;

  tsf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  tsf_fstore u_fstore (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  tsf_blend u_blend (
    .pix_in (mem_rdata),
    .fill   ({fill2_r, fill1_r, fill0_r}),
    .alpha  (alpha_r),
    .pix_out(blend_out)
  );

  // Slope operands: edge A-B, A-C, then B-C.
  always_comb begin
    case (dsel_r)
      2'd0: begin
        d_x = $signed({bx_r[CRD_W-1], bx_r}) - $signed({ax_r[CRD_W-1], ax_r});
        d_y = $signed({by_r[CRD_W-1], by_r}) - $signed({ay_r[CRD_W-1], ay_r});
      end
      2'd1: begin
        d_x = $signed({cx_r[CRD_W-1], cx_r}) - $signed({ax_r[CRD_W-1], ax_r});
        d_y = $signed({cy_r[CRD_W-1], cy_r}) - $signed({ay_r[CRD_W-1], ay_r});
      end
      default: begin
        d_x = $signed({cx_r[CRD_W-1], cx_r}) - $signed({bx_r[CRD_W-1], bx_r});
        d_y = $signed({cy_r[CRD_W-1], cy_r}) - $signed({by_r[CRD_W-1], by_r});
      end
    endcase
  end

  assign dy_zero    = (d_y == '0);
  // A flat top edge steps by the plain x difference; the other edges by zero.
  assign flat_slope = (dsel_r == 2'd0) ? $signed({d_x, {FRAC_W{1'b0}}}) : '0;

  assign div_req.start    = (state_r == ST_DIV_START) && !dy_zero;
  assign div_req.dividend = $signed({d_x, {FRAC_W{1'b0}}});
  assign div_req.divisor  = d_y[CRD_W-1:0];

  // Row bounds and the clipped span of the current row.
  assign end_y    = phase_r ? $signed({cy_r[CRD_W-1], cy_r}) : $signed({by_r[CRD_W-1], by_r});
  assign row_over = (y_r > end_y);
  assign lo_pos   = $signed({{(POS_W-CLIP_W-FRAC_W){1'b0}}, cminx_r, {FRAC_W{1'b0}}});
  assign hi_pos   = $signed({{(POS_W-CLIP_W-FRAC_W){1'b0}}, cmaxx_r, {FRAC_W{1'b0}}});
  assign drop     = (y_r < $signed({{(YW-CLIP_W){1'b0}}, cminy_r}))
                 || (y_r > $signed({{(YW-CLIP_W){1'b0}}, cmaxy_r}))
                 || (ex_r < lo_pos) || (sx_r > hi_pos);
  assign xs_c     = (sx_r < lo_pos) ? lo_pos : sx_r;
  assign xe_c     = (ex_r > hi_pos) ? hi_pos : ex_r;
  // Both clamped ends are non-negative here, so rounding is add-half and shift.
  assign xs_r     = xs_c + POS_W'(HALF_Q16);
  assign xe_r     = xe_c + POS_W'(HALF_Q16);
  assign cs       = xs_r[FRAC_W +: COL_W];
  assign ce       = xe_r[FRAC_W +: COL_W];
  assign span_live = !drop && (cs < ce);
  assign col_inc  = {1'b0, col_r} + (COL_W+1)'(1);

  // Edge increments for the current half of the triangle.
  always_comb begin
    if (phase_r) begin
      inc_s = sel_r ? slope_to_pos(dx2_r) : slope_to_pos(dx3_r);
      inc_e = sel_r ? slope_to_pos(dx3_r) : slope_to_pos(dx2_r);
    end else begin
      inc_s = sel_r ? slope_to_pos(dx2_r) : slope_to_pos(dx1_r);
      inc_e = sel_r ? slope_to_pos(dx1_r) : slope_to_pos(dx2_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (clr_addr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_item.operation == OP_READ) ? ST_RD_REQ : ST_SORT;
        end
      end
      ST_RD_REQ:    state_nxt = ST_RD_DATA;
      ST_RD_DATA:   state_nxt = ST_IDLE;
      ST_SORT:      state_nxt = ST_DIV_START;
      ST_DIV_START: begin
        if (!dy_zero) begin
          state_nxt = ST_DIV_WAIT;
        end else if (dsel_r == 2'd2) begin
          state_nxt = ST_INIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (dsel_r == 2'd2) ? ST_INIT : ST_DIV_START;
        end
      end
      ST_INIT:      state_nxt = ST_ROW;
      ST_ROW: begin
        if (row_over) begin
          if (phase_r) state_nxt = ST_DONE;
        end else if (span_live) begin
          state_nxt = ST_PIX_RD;
        end
      end
      ST_PIX_RD:    state_nxt = ST_PIX_WR;
      ST_PIX_WR:    state_nxt = (col_inc[COL_W-1:0] == ce_r) ? ST_ROW : ST_PIX_RD;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic signed [CRD_W-1:0] p0x, p0y, p1x, p1y, p2x, p2y, tx, ty;
    clr_addr_nxt  = clr_addr_r;
    item_nxt      = item_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r;
    by_nxt = by_r; cx_nxt = cx_r; cy_nxt = cy_r;
    dx1_nxt = dx1_r; dx2_nxt = dx2_r; dx3_nxt = dx3_r;
    dsel_nxt      = dsel_r;
    sx_nxt        = sx_r;
    ex_nxt        = ex_r;
    y_nxt         = y_r;
    phase_nxt     = phase_r;
    sel_nxt       = sel_r;
    col_nxt       = col_r;
    ce_nxt        = ce_r;
    row_nxt       = row_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = {row_r, col_r};
    mem_req.wdata = blend_out;
    mem_req.raddr = {row_r, col_r};

    // Stable three-element sort by row.
    p0x = item_r.first_x;  p0y = item_r.first_y;
    p1x = item_r.second_x; p1y = item_r.second_y;
    p2x = item_r.third_x;  p2y = item_r.third_y;
    if (p1y < p0y) begin
      tx = p0x; ty = p0y; p0x = p1x; p0y = p1y; p1x = tx; p1y = ty;
    end
    if (p2y < p1y) begin
      tx = p2x; ty = p2y; p2x = p1x; p2y = p1y; p1x = tx; p1y = ty;
      if (p1y < p0y) begin
        tx = p0x; ty = p0y; p0x = p1x; p0y = p1y; p1x = tx; p1y = ty;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (start) item_nxt = in_item;
      end
      ST_RD_REQ: begin
        mem_req.raddr = {item_r.read_row[ROW_W-1:0], item_r.read_col[COL_W-1:0]};
      end
      ST_RD_DATA: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.kind        = KIND_PIXEL;
        out_item_nxt.pixel_chan0 = mem_rdata[0*CH_W +: CH_W];
        out_item_nxt.pixel_chan1 = mem_rdata[1*CH_W +: CH_W];
        out_item_nxt.pixel_chan2 = mem_rdata[2*CH_W +: CH_W];
        out_item_nxt.pixel_chan3 = '0;
      end
      ST_SORT: begin
        ax_nxt = p0x; ay_nxt = p0y;
        bx_nxt = p1x; by_nxt = p1y;
        cx_nxt = p2x; cy_nxt = p2y;
        dsel_nxt = 2'd0;
      end
      ST_DIV_START: begin
        if (dy_zero) begin
          case (dsel_r)
            2'd0:    dx1_nxt = flat_slope;
            2'd1:    dx2_nxt = flat_slope;
            default: dx3_nxt = flat_slope;
          endcase
          dsel_nxt = dsel_r + 2'd1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (dsel_r)
            2'd0:    dx1_nxt = div_rsp.quotient;
            2'd1:    dx2_nxt = div_rsp.quotient;
            default: dx3_nxt = div_rsp.quotient;
          endcase
          dsel_nxt = dsel_r + 2'd1;
        end
      end
      ST_INIT: begin
        sx_nxt    = coord_to_pos(ax_r);
        ex_nxt    = coord_to_pos(ax_r);
        y_nxt     = $signed({ay_r[CRD_W-1], ay_r});
        phase_nxt = 1'b0;
        sel_nxt   = (dx1_r > dx2_r);
      end
      ST_ROW: begin
        if (row_over) begin
          // Lower half starts one row below the middle vertex.
          if (!phase_r) begin
            phase_nxt = 1'b1;
            y_nxt     = $signed({by_r[CRD_W-1], by_r}) + YW'(1);
            if (sel_r) begin
              ex_nxt = coord_to_pos(bx_r) + slope_to_pos(dx3_r);
            end else begin
              sx_nxt = coord_to_pos(bx_r) + slope_to_pos(dx3_r);
            end
          end
        end else begin
          col_nxt = cs;
          ce_nxt  = ce;
          row_nxt = y_r[ROW_W-1:0];
          sx_nxt  = sx_r + inc_s;
          ex_nxt  = ex_r + inc_e;
          y_nxt   = y_r + YW'(1);
        end
      end
      ST_PIX_RD: begin
        mem_req.raddr = {row_r, col_r};
      end
      ST_PIX_WR: begin
        mem_req.we = 1'b1;
        col_nxt    = col_inc[COL_W-1:0];
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        out_item_nxt.kind = KIND_DONE;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill0_r <= '0;
      fill1_r <= '0;
      fill2_r <= '0;
      alpha_r <= ALPHA_OPAQUE;
      cminx_r <= '0;
      cmaxx_r <= CLIP_W'(63);
      cminy_r <= '0;
      cmaxy_r <= CLIP_W'(63);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILL_CHAN0: fill0_r <= cfg_wdata;
        REG_FILL_CHAN1: fill1_r <= cfg_wdata;
        REG_FILL_CHAN2: fill2_r <= cfg_wdata;
        REG_FILL_ALPHA: alpha_r <= cfg_wdata;
        REG_CLIP_MIN_X: cminx_r <= cfg_wdata[CLIP_W-1:0];
        REG_CLIP_MAX_X: cmaxx_r <= cfg_wdata[CLIP_W-1:0];
        REG_CLIP_MIN_Y: cminy_r <= cfg_wdata[CLIP_W-1:0];
        REG_CLIP_MAX_Y: cmaxy_r <= cfg_wdata[CLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt;
    by_r <= by_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    dx1_r <= dx1_nxt; dx2_r <= dx2_nxt; dx3_r <= dx3_nxt;
    dsel_r     <= dsel_nxt;
    sx_r       <= sx_nxt;
    ex_r       <= ex_nxt;
    y_r        <= y_nxt;
    phase_r    <= phase_nxt;
    sel_r      <= sel_nxt;
    col_r      <= col_nxt;
    ce_r       <= ce_nxt;
    row_r      <= row_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the scanline triangle fill core.
// A behavioral model of the frame store and the edge walk predicts the
// result of every item. Directed cases run first, then random triangles and
// pixel reads under several fill and clip settings. Every result strobe is
// compared field by field with the oldest prediction.
// ============================================================================
module tb_top;
  import tsf_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  triangle_scanline_fill_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Model of the frame store and of the fill settings.
  logic [7:0] pix_mem [FB_WIDTH*FB_HEIGHT][CHANNELS];
  logic [7:0] fill_val [4];
  longint     clip_x0, clip_x1, clip_y0, clip_y1;

  out_item_t  pending_px[$];
  int         mismatch_cnt;
  int         item_cnt;
  int         draw_cnt;
  int         read_cnt;
  int         result_cnt;
  bit         no_idle;

  // Clock: 2 ns period.
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Blend one channel value over the stored one.
  function automatic logic [7:0] blend_chan(logic [7:0] c, logic [7:0] t);
    int unsigned a;
    int unsigned r;
    a = fill_val[3];
    if (fill_val[3] == ALPHA_OPAQUE) return c;
    r = (c * a + t * (255 - a)) / 255;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic longint round_pos(longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  // Clip one row span and paint its pixels into the model.
  function automatic void paint_span(longint xs, longint xe, longint y);
    longint lo;
    longint hi;
    longint cs;
    longint ce;
    int     idx;
    lo = clip_x0 * 65536;
    hi = clip_x1 * 65536;
    if (y < clip_y0 || y > clip_y1 || xe < lo || xs > hi) return;
    if (xs < lo) xs = lo;
    if (xe > hi) xe = hi;
    cs = round_pos(xs);
    ce = round_pos(xe);
    for (longint c = cs; c < ce; c++) begin
      if (c >= 0 && c < FB_WIDTH && y >= 0 && y < FB_HEIGHT) begin
        idx = int'(y) * FB_WIDTH + int'(c);
        for (int ch = 0; ch < CHANNELS; ch++)
          pix_mem[idx][ch] = blend_chan(fill_val[ch], pix_mem[idx][ch]);
      end
    end
  endfunction

  function automatic longint edge_slope(longint dx, longint dy, longint flat);
    if (dy > 0) return (dx * 65536) / dy;
    return flat;
  endfunction

  // Sort the vertices by row, walk both edges and paint every span.
  function automatic void rasterize(in_item_t it);
    longint vx[3];
    longint vy[3];
    longint tx;
    longint ty;
    longint d1, d2, d3, sx, ex, y;
    vx[0] = it.first_x;  vy[0] = it.first_y;
    vx[1] = it.second_x; vy[1] = it.second_y;
    vx[2] = it.third_x;  vy[2] = it.third_y;
    // Stable sort: equal rows keep their input order.
    if (vy[1] < vy[0]) begin
      tx = vx[0]; ty = vy[0]; vx[0] = vx[1]; vy[0] = vy[1]; vx[1] = tx; vy[1] = ty;
    end
    if (vy[2] < vy[1]) begin
      tx = vx[2]; ty = vy[2]; vx[2] = vx[1]; vy[2] = vy[1]; vx[1] = tx; vy[1] = ty;
      if (vy[1] < vy[0]) begin
        tx = vx[0]; ty = vy[0]; vx[0] = vx[1]; vy[0] = vy[1]; vx[1] = tx; vy[1] = ty;
      end
    end
    d1 = edge_slope(vx[1] - vx[0], vy[1] - vy[0], (vx[1] - vx[0]) * 65536);
    d2 = edge_slope(vx[2] - vx[0], vy[2] - vy[0], 0);
    d3 = edge_slope(vx[2] - vx[1], vy[2] - vy[1], 0);
    sx = vx[0] * 65536;
    ex = sx;
    y  = vy[0];
    if (d1 > d2) begin
      for (y = vy[0]; y <= vy[1]; y++) begin
        paint_span(sx, ex, y); sx += d2; ex += d1;
      end
      ex = vx[1] * 65536 + d3;
      for (y = vy[1] + 1; y <= vy[2]; y++) begin
        paint_span(sx, ex, y); sx += d2; ex += d3;
      end
    end else begin
      for (y = vy[0]; y <= vy[1]; y++) begin
        paint_span(sx, ex, y); sx += d1; ex += d2;
      end
      sx = vx[1] * 65536 + d3;
      for (y = vy[1] + 1; y <= vy[2]; y++) begin
        paint_span(sx, ex, y); sx += d3; ex += d2;
      end
    end
  endfunction

  // Expected result of one accepted item; a draw also updates the model.
  function automatic out_item_t predict_pixel_result(in_item_t it);
    out_item_t r;
    int        idx;
    r = '0;
    if (it.operation == OP_DRAW) begin
      rasterize(it);
      r.kind = KIND_DONE;
    end else begin
      idx = int'(it.read_row) * FB_WIDTH + int'(it.read_col);
      r.kind = KIND_PIXEL;
      r.pixel_chan0 = pix_mem[idx][0];
      r.pixel_chan1 = pix_mem[idx][1];
      r.pixel_chan2 = pix_mem[idx][2];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    $display("[%0t] result %0d: %s is %0d, want %0d", $time, result_cnt, what, got, want);
  endtask

  // Compare each result strobe with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result, kind", out_item.kind, -1);
      end else begin
        want = pending_px.pop_front();
        if (out_item.kind !== want.kind)
          report_mismatch("kind", out_item.kind, want.kind);
        if (out_item.pixel_chan0 !== want.pixel_chan0)
          report_mismatch("pixel_chan0", out_item.pixel_chan0, want.pixel_chan0);
        if (out_item.pixel_chan1 !== want.pixel_chan1)
          report_mismatch("pixel_chan1", out_item.pixel_chan1, want.pixel_chan1);
        if (out_item.pixel_chan2 !== want.pixel_chan2)
          report_mismatch("pixel_chan2", out_item.pixel_chan2, want.pixel_chan2);
        if (out_item.pixel_chan3 !== want.pixel_chan3)
          report_mismatch("pixel_chan3", out_item.pixel_chan3, want.pixel_chan3);
      end
      result_cnt++;
    end
  end

  // Send one item; start stays high after acceptance for a back-to-back item.
  task automatic send_item(in_item_t it);
    int gap;
    if (!no_idle && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_px.push_back(predict_pixel_result(it));
    item_cnt++;
    if (it.operation == OP_DRAW) draw_cnt++;
    else read_cnt++;
  endtask

  // Lower start and wait until every predicted result has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write; the caller drains first and ends the burst with cfg_done.
  task automatic write_reg(cfg_reg_t idx, int val);
    logic [7:0] v;
    v = val[7:0];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_FILL_CHAN0: fill_val[0] = v;
      REG_FILL_CHAN1: fill_val[1] = v;
      REG_FILL_CHAN2: fill_val[2] = v;
      REG_FILL_ALPHA: fill_val[3] = v;
      REG_CLIP_MIN_X: clip_x0 = v[5:0];
      REG_CLIP_MAX_X: clip_x1 = v[5:0];
      REG_CLIP_MIN_Y: clip_y0 = v[5:0];
      REG_CLIP_MAX_Y: clip_y1 = v[5:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_fill(int c0, int c1, int c2, int a);
    drain();
    write_reg(REG_FILL_CHAN0, c0);
    write_reg(REG_FILL_CHAN1, c1);
    write_reg(REG_FILL_CHAN2, c2);
    write_reg(REG_FILL_ALPHA, a);
    cfg_done();
  endtask

  task automatic set_clip(int x0, int x1, int y0, int y1);
    drain();
    write_reg(REG_CLIP_MIN_X, x0);
    write_reg(REG_CLIP_MAX_X, x1);
    write_reg(REG_CLIP_MIN_Y, y0);
    write_reg(REG_CLIP_MAX_Y, y1);
    cfg_done();
  endtask

  function automatic in_item_t make_draw(int ax, int ay, int bx, int by, int cx, int cy);
    in_item_t it;
    it.operation = OP_DRAW;
    it.first_x  = ax[11:0]; it.first_y  = ay[11:0];
    it.second_x = bx[11:0]; it.second_y = by[11:0];
    it.third_x  = cx[11:0]; it.third_y  = cy[11:0];
    it.read_col = $urandom_range(63);
    it.read_row = $urandom_range(63);
    return it;
  endfunction

  function automatic in_item_t make_read(int col, int row);
    in_item_t it;
    it = make_draw($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
    it.operation = OP_READ;
    it.read_col  = col[5:0];
    it.read_row  = row[5:0];
    return it;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // A small triangle whose vertices lie within a box around a random corner.
  function automatic in_item_t small_draw(int reach);
    int bx;
    int by;
    bx = pick(-12, 70);
    by = pick(-12, 70);
    return make_draw(bx + pick(-reach, reach), by + pick(-reach, reach),
                     bx + pick(-reach, reach), by + pick(-reach, reach),
                     bx + pick(-reach, reach), by + pick(-reach, reach));
  endfunction

  // Extremes of the coordinates, both slope orders, flat edges and reads.
  task automatic test_directed();
    set_fill(255, 0, 128, 255);
    send_item(make_draw(10, 5, 30, 20, 5, 40));
    send_item(make_draw(40, 2, 10, 30, 60, 50));
    send_item(make_draw(5, 10, 40, 10, 20, 30));
    send_item(make_draw(20, 8, 3, 35, 50, 35));
    send_item(make_draw(30, 30, 30, 30, 30, 30));
    send_item(make_draw(15, 0, 15, 63, 15, 20));
    send_item(make_draw(-2048, -2048, 2047, 2047, -2048, 2047));
    send_item(make_draw(2047, -2048, -2048, 2047, 2047, 0));
    send_item(make_read(20, 20));
    send_item(make_read(0, 0));
    send_item(make_read(63, 63));
    // Blended fill, alpha zero leaves the store unchanged.
    set_fill(200, 100, 50, 77);
    send_item(make_draw(0, 0, 63, 0, 0, 63));
    send_item(make_read(5, 5));
    set_fill(255, 255, 255, 0);
    send_item(make_draw(0, 0, 63, 63, 0, 63));
    send_item(make_read(2, 40));
    // Right clip column and a reversed clip rectangle.
    set_fill(9, 8, 7, 255);
    set_clip(10, 20, 10, 20);
    send_item(make_draw(0, 0, 63, 0, 0, 63));
    send_item(make_read(20, 15));
    send_item(make_read(19, 15));
    set_clip(40, 5, 50, 3);
    send_item(make_draw(0, 0, 63, 0, 0, 63));
    send_item(make_read(30, 30));
    // Upper bits of clip writes are dropped.
    set_clip(192, 255, 128, 191);
  endtask

  // Random triangles and reads under one setting.
  task automatic test_random_phase(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 28)
        send_item(make_read($urandom_range(63), $urandom_range(63)));
      else if (sel < 30)
        send_item(make_draw($urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(4095)));
      else if (sel < 40)
        send_item(small_draw(40));
      else
        send_item(small_draw(12));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      set_fill($urandom_range(255), $urandom_range(255), $urandom_range(255),
               ($urandom_range(2) == 0) ? 255 : $urandom_range(255));
      case (ph % 4)
        0: set_clip(0, 63, 0, 63);
        1: set_clip($urandom_range(63), $urandom_range(63),
                    $urandom_range(63), $urandom_range(63));
        2: set_clip($urandom_range(20), 43 + $urandom_range(20),
                    $urandom_range(20), 43 + $urandom_range(20));
        default: set_clip(63, 0, 63, 0);
      endcase
      no_idle = (ph == 3);
      test_random_phase(115);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatch_cnt = 0;
    item_cnt  = 0;
    draw_cnt  = 0;
    read_cnt  = 0;
    result_cnt = 0;
    no_idle   = 1'b0;
    for (int i = 0; i < FB_WIDTH * FB_HEIGHT; i++)
      for (int ch = 0; ch < CHANNELS; ch++) pix_mem[i][ch] = 8'd0;
    fill_val[0] = 0; fill_val[1] = 0; fill_val[2] = 0; fill_val[3] = 8'd255;
    clip_x0 = 0; clip_x1 = 63; clip_y0 = 0; clip_y1 = 63;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d items (%0d triangles, %0d pixel reads), %0d results checked,",
             item_cnt, draw_cnt, read_cnt, result_cnt);
    $display("under opaque and blended fills and full, partial and reversed clip windows.");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Time limit for the whole run.
  initial begin
    #200000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
